// ----- rtl/rsls_pkg.sv -----
// Shared types, register indexes and helpers for the ray-sphere Lambert shade unit.
// No dependencies; rsls_norm3 and the top-level unit refer to this package by scoped names.
`default_nettype none

package rsls_pkg;

    typedef logic signed [63:0] s64_t;

    typedef struct packed {
        logic hit;
        logic zs;
    } flags_t;

    localparam logic [2:0] REG_OFFSET_X = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z = 3'd2;
    localparam logic [2:0] REG_VIEW_X   = 3'd3;
    localparam logic [2:0] REG_VIEW_Y   = 3'd4;
    localparam logic [2:0] REG_VIEW_Z   = 3'd5;
    localparam logic [2:0] REG_RADIUS   = 3'd6;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        logic signed [31:0] r;
        if (x[33:31] != {3{x[33]}}) begin
            r = x[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rsls_norm3.sv -----
// Block-exponent normalizer for a 3-vector: five stages (magnitude, max, byte scan,
// bit length, shift). Depends on rsls_pkg for the 64-bit signed type.
`default_nettype none

module rsls_norm3 #(
    parameter int HB = 30,
    parameter int SW = 1
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_vld,
    input  wire rsls_pkg::s64_t      in_v0,
    input  wire rsls_pkg::s64_t      in_v1,
    input  wire rsls_pkg::s64_t      in_v2,
    input  wire logic [SW-1:0]       in_side,
    output logic                     out_vld,
    output logic signed [HB:0]       out_v0,
    output logic signed [HB:0]       out_v1,
    output logic signed [HB:0]       out_v2,
    output logic [SW-1:0]            out_side
);

    logic           vld_reg [1:5];
    logic [SW-1:0]  side_reg [1:5];
    rsls_pkg::s64_t v1_reg [3];
    rsls_pkg::s64_t v2_reg [3];
    rsls_pkg::s64_t v3_reg [3];
    rsls_pkg::s64_t v4_reg [3];
    logic [63:0]    mag1_reg [3];
    logic [63:0]    max2_reg;
    logic [7:0]     nz3_reg;
    logic [7:0][2:0] pos3_reg;
    logic [6:0]     blen4_reg;
    logic signed [HB:0] o_reg [3];

    logic [63:0]     max2_next;
    logic [7:0]      nz3_next;
    logic [7:0][2:0] pos3_next;
    logic [6:0]      blen4_next;
    logic signed [HB:0] o_next [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= 5; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[1] <= in_vld;
            for (int i = 2; i <= 5; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_comb begin
        max2_next = mag1_reg[0];
        if (mag1_reg[1] > max2_next) max2_next = mag1_reg[1];
        if (mag1_reg[2] > max2_next) max2_next = mag1_reg[2];
    end

    always_comb begin
        for (int c = 0; c < 8; c++) begin
            nz3_next[c]  = |max2_reg[8*c +: 8];
            pos3_next[c] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (max2_reg[8*c + b]) pos3_next[c] = 3'(b);
            end
        end
    end

    always_comb begin
        blen4_next = 7'd0;
        for (int c = 0; c < 8; c++) begin
            if (nz3_reg[c]) blen4_next = 7'(8*c) + 7'(pos3_reg[c]) + 7'd1;
        end
    end

    always_comb begin
        logic [6:0] sh;
        rsls_pkg::s64_t t;
        sh = 7'd0;
        for (int i = 0; i < 3; i++) begin
            if (blen4_reg > 7'(HB)) begin
                sh = blen4_reg - 7'(HB);
                t  = v4_reg[i] >>> sh;
            end else begin
                sh = 7'(HB) - blen4_reg;
                t  = v4_reg[i] <<< sh;
            end
            o_next[i] = t[HB:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[1] <= in_side;
            for (int i = 2; i <= 5; i++) side_reg[i] <= side_reg[i-1];
            v1_reg[0] <= in_v0;
            v1_reg[1] <= in_v1;
            v1_reg[2] <= in_v2;
            mag1_reg[0] <= in_v0[63] ? 64'(-in_v0) : 64'(in_v0);
            mag1_reg[1] <= in_v1[63] ? 64'(-in_v1) : 64'(in_v1);
            mag1_reg[2] <= in_v2[63] ? 64'(-in_v2) : 64'(in_v2);
            for (int i = 0; i < 3; i++) begin
                v2_reg[i] <= v1_reg[i];
                v3_reg[i] <= v2_reg[i];
                v4_reg[i] <= v3_reg[i];
                o_reg[i]  <= o_next[i];
            end
            max2_reg  <= max2_next;
            nz3_reg   <= nz3_next;
            pos3_reg  <= pos3_next;
            blen4_reg <= blen4_next;
        end
    end

    assign out_vld  = vld_reg[5];
    assign out_side = side_reg[5];
    assign out_v0   = o_reg[0];
    assign out_v1   = o_reg[1];
    assign out_v2   = o_reg[2];

endmodule

`default_nettype wire

// ----- rtl/rsls_isqrt.sv -----
// Pipelined integer square root, one result bit per stage (floor of sqrt).
// Carries a sideband word alongside; no package dependencies.
`default_nettype none

module rsls_isqrt #(
    parameter int IW = 62,
    parameter int SW = 1
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_vld,
    input  wire logic [IW-1:0]       in_x,
    input  wire logic [SW-1:0]       in_side,
    output logic                     out_vld,
    output logic [IW/2-1:0]          out_root,
    output logic [SW-1:0]            out_side
);

    localparam int OW = IW / 2;

    logic          vld_reg  [0:OW];
    logic [IW:0]   rem_reg  [0:OW];
    logic [OW-1:0] root_reg [0:OW];
    logic [SW-1:0] side_reg [0:OW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= {1'b0, in_x};
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar j = 0; j < OW; j++) begin : g_step
        localparam int K = OW - 1 - j;
        logic [IW:0] trial;
        logic        take;

        assign trial = ({{(IW+1-OW){1'b0}}, root_reg[j]} << (K + 1))
                     | ((IW+1)'(1) << (2 * K));
        assign take  = rem_reg[j] >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1]  <= take ? rem_reg[j] - trial : rem_reg[j];
                root_reg[j+1] <= take ? (root_reg[j] | (OW'(1) << K)) : root_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_vld  = vld_reg[OW];
    assign out_root = root_reg[OW];
    assign out_side = side_reg[OW];

endmodule

`default_nettype wire

// ----- rtl/rsls_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag
// for quotients that do not fit. Carries a sideband word; no package dependencies.
`default_nettype none

module rsls_div #(
    parameter int NW = 48,
    parameter int DW = 30,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_vld,
    input  wire logic [NW-1:0]       in_num,
    input  wire logic [DW-1:0]       in_den,
    input  wire logic [SW-1:0]       in_side,
    output logic                     out_vld,
    output logic [QW-1:0]            out_quo,
    output logic                     out_ov,
    output logic [SW-1:0]            out_side
);

    localparam int RW = (NW > DW + QW) ? NW : DW + QW;

    logic          vld_reg  [0:QW];
    logic [RW-1:0] rem_reg  [0:QW];
    logic [DW-1:0] den_reg  [0:QW];
    logic [QW-1:0] quo_reg  [0:QW];
    logic          ov_reg   [0:QW];
    logic [SW-1:0] side_reg [0:QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= RW'(in_num);
            den_reg[0]  <= in_den;
            quo_reg[0]  <= '0;
            ov_reg[0]   <= RW'(in_num) >= (RW'(in_den) << QW);
            side_reg[0] <= in_side;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_step
        localparam int I = QW - 1 - j;
        logic [RW-1:0] sub;
        logic          take;

        assign sub  = RW'(den_reg[j]) << I;
        assign take = rem_reg[j] >= sub;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1]  <= take ? rem_reg[j] - sub : rem_reg[j];
                quo_reg[j+1]  <= take ? (quo_reg[j] | (QW'(1) << I)) : quo_reg[j];
                den_reg[j+1]  <= den_reg[j];
                ov_reg[j+1]   <= ov_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_vld  = vld_reg[QW];
    assign out_quo  = quo_reg[QW];
    assign out_ov   = ov_reg[QW];
    assign out_side = side_reg[QW];

endmodule

`default_nettype wire

// ----- rtl/ray_sphere_lambert_shade_unit.sv -----
// Ray-sphere hit test with Lambert shading, one pixel per transaction.
// Depends on rsls_pkg, rsls_norm3, rsls_isqrt and rsls_div.
//
// Usage:
//   s_ channel: s_tdata[14:0] = screen_u, s_tdata[29:15] = screen_v (signed Q1.14).
//   m_ channel: m_tdata[15:0] = shade (Q0.16), m_tuser = ray_hit.
//   APB port: seven registers at byte addresses 0x00..0x18 (offset x/y/z,
//   view direction x/y/z, radius); write them only while no pixel is in flight.
// Depth: the two square roots (32 and 33 stages) and the two dividers (33 and 17
//   stages) make up most of the pipeline from input transaction to output register.
// Throughput: one pixel per cycle while the skid register is empty; every stage advances together.
// Reset: aresetn (synchronous, active low) empties the pipeline and loads the
//   registers with offset (0,0,3), view (0,0,-1), radius 0.5.
// Stall: when m_tready is low while a result waits, the next result lands in a skid register
//   and the pipeline then holds; s_tready follows the skid being empty.
`default_nettype none

module ray_sphere_lambert_shade_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [14:0] screen_u, [29:15] screen_v
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] shade
    output logic             m_tuser,   // [0] ray_hit
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LSH = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
    localparam int RSH = (FRAC_BITS >= 14) ? 0 : 14 - FRAC_BITS;

    // ---------------- configuration ----------------
    logic signed [31:0] off_reg  [3];
    logic signed [31:0] vdir_reg [3];
    logic [30:0]        rad_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg[0]  <= '0;
            off_reg[1]  <= '0;
            off_reg[2]  <= 32'(3) << FRAC_BITS;
            vdir_reg[0] <= '0;
            vdir_reg[1] <= '0;
            vdir_reg[2] <= -(32'(1) << FRAC_BITS);
            rad_reg     <= 31'(1) << (FRAC_BITS - 1);
        end else if (cfg_wr) begin
            case (paddr[4:2])
                rsls_pkg::REG_OFFSET_X: off_reg[0]  <= pwdata;
                rsls_pkg::REG_OFFSET_Y: off_reg[1]  <= pwdata;
                rsls_pkg::REG_OFFSET_Z: off_reg[2]  <= pwdata;
                rsls_pkg::REG_VIEW_X:   vdir_reg[0] <= pwdata;
                rsls_pkg::REG_VIEW_Y:   vdir_reg[1] <= pwdata;
                rsls_pkg::REG_VIEW_Z:   vdir_reg[2] <= pwdata;
                rsls_pkg::REG_RADIUS:   rad_reg     <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            rsls_pkg::REG_OFFSET_X: prdata = off_reg[0];
            rsls_pkg::REG_OFFSET_Y: prdata = off_reg[1];
            rsls_pkg::REG_OFFSET_Z: prdata = off_reg[2];
            rsls_pkg::REG_VIEW_X:   prdata = vdir_reg[0];
            rsls_pkg::REG_VIEW_Y:   prdata = vdir_reg[1];
            rsls_pkg::REG_VIEW_Z:   prdata = vdir_reg[2];
            rsls_pkg::REG_RADIUS:   prdata = {1'b0, rad_reg};
            default:                prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic skid_vld_reg;

    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // ---------------- ray direction ----------------
    logic               dir_vld_reg;
    logic signed [31:0] dir_x_reg, dir_y_reg;
    logic signed [33:0] u_al, v_al;

    assign u_al = (34'($signed(s_tdata[14:0])) <<< LSH) >>> RSH;
    assign v_al = (34'($signed(s_tdata[29:15])) <<< LSH) >>> RSH;

    always_ff @(posedge aclk) begin
        if (!aresetn) dir_vld_reg <= 1'b0;
        else if (en) dir_vld_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dir_x_reg <= rsls_pkg::sat32(34'(vdir_reg[0]) + u_al);
            dir_y_reg <= rsls_pkg::sat32(34'(vdir_reg[1]) + v_al);
        end
    end

    // ---------------- quadratic products ----------------
    logic               prod_vld_reg;
    logic signed [31:0] dvec [3];
    logic signed [63:0] prod_dd_reg [3];
    logic signed [63:0] prod_do_reg [3];
    logic signed [63:0] prod_oo_reg [3];
    logic [61:0]        prod_rr_reg;
    logic signed [31:0] prod_dx_reg, prod_dy_reg;

    always_comb begin
        dvec[0] = dir_x_reg;
        dvec[1] = dir_y_reg;
        dvec[2] = vdir_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) prod_vld_reg <= 1'b0;
        else if (en) prod_vld_reg <= dir_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod_dd_reg[i] <= 64'(dvec[i]) * 64'(dvec[i]);
                prod_do_reg[i] <= 64'(dvec[i]) * 64'(off_reg[i]);
                prod_oo_reg[i] <= 64'(off_reg[i]) * 64'(off_reg[i]);
            end
            prod_rr_reg <= 62'(rad_reg) * 62'(rad_reg);
            prod_dx_reg <= dir_x_reg;
            prod_dy_reg <= dir_y_reg;
        end
    end

    // ---------------- partial sums ----------------
    logic               psum_vld_reg;
    rsls_pkg::s64_t     psum_a01_reg, psum_a2_reg, psum_h01_reg, psum_h2_reg;
    rsls_pkg::s64_t     psum_c01_reg, psum_c2_reg;
    logic signed [31:0] psum_dx_reg, psum_dy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) psum_vld_reg <= 1'b0;
        else if (en) psum_vld_reg <= prod_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            psum_a01_reg <= (prod_dd_reg[0] >>> 2) + (prod_dd_reg[1] >>> 2);
            psum_a2_reg  <= prod_dd_reg[2] >>> 2;
            psum_h01_reg <= (prod_do_reg[0] >>> 2) + (prod_do_reg[1] >>> 2);
            psum_h2_reg  <= prod_do_reg[2] >>> 2;
            psum_c01_reg <= (prod_oo_reg[0] >>> 2) + (prod_oo_reg[1] >>> 2);
            psum_c2_reg  <= (prod_oo_reg[2] >>> 2) - $signed({4'b0, prod_rr_reg[61:2]});
            psum_dx_reg  <= prod_dx_reg;
            psum_dy_reg  <= prod_dy_reg;
        end
    end

    // ---------------- a, h, c ----------------
    logic               quad_vld_reg;
    rsls_pkg::s64_t     quad_q0_reg, quad_q1_reg, quad_q2_reg;
    rsls_pkg::s64_t     quad_q0_next, quad_q1_next, quad_q2_next;
    logic               quad_qz_reg;
    logic signed [31:0] quad_dx_reg, quad_dy_reg;

    assign quad_q0_next = psum_a01_reg + psum_a2_reg;
    assign quad_q1_next = psum_h01_reg + psum_h2_reg;
    assign quad_q2_next = psum_c01_reg + psum_c2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) quad_vld_reg <= 1'b0;
        else if (en) quad_vld_reg <= psum_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quad_q0_reg <= quad_q0_next;
            quad_q1_reg <= quad_q1_next;
            quad_q2_reg <= quad_q2_next;
            quad_qz_reg <= (quad_q0_next == 0) && (quad_q1_next == 0) && (quad_q2_next == 0);
            quad_dx_reg <= psum_dx_reg;
            quad_dy_reg <= psum_dy_reg;
        end
    end

    // ---------------- common scaling of a, h, c ----------------
    logic               n1_vld;
    logic signed [30:0] n1_q0, n1_q1, n1_q2;
    logic [64:0]        n1_side;

    rsls_norm3 #(.HB(30), .SW(65)) u_norm_quad (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (quad_vld_reg),
        .in_v0    (quad_q0_reg),
        .in_v1    (quad_q1_reg),
        .in_v2    (quad_q2_reg),
        .in_side  ({quad_dx_reg, quad_dy_reg, quad_qz_reg}),
        .out_vld  (n1_vld),
        .out_v0   (n1_q0),
        .out_v1   (n1_q1),
        .out_v2   (n1_q2),
        .out_side (n1_side)
    );

    // ---------------- discriminant ----------------
    logic               qsq_vld_reg;
    logic signed [61:0] qsq_p11_reg, qsq_p02_reg;
    logic signed [30:0] qsq_q0_reg, qsq_q1_reg;
    logic signed [31:0] qsq_dx_reg, qsq_dy_reg;
    logic               qsq_qz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) qsq_vld_reg <= 1'b0;
        else if (en) qsq_vld_reg <= n1_vld;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qsq_p11_reg <= 62'(n1_q1) * 62'(n1_q1);
            qsq_p02_reg <= 62'(n1_q0) * 62'(n1_q2);
            qsq_q0_reg  <= n1_q0;
            qsq_q1_reg  <= n1_q1;
            qsq_dx_reg  <= n1_side[64:33];
            qsq_dy_reg  <= n1_side[32:1];
            qsq_qz_reg  <= n1_side[0];
        end
    end

    logic               disc_vld_reg;
    logic [61:0]        disc_x_reg;
    logic signed [30:0] disc_q0_reg, disc_q1_reg;
    logic signed [31:0] disc_dx_reg, disc_dy_reg;
    rsls_pkg::flags_t   disc_flags_reg;
    logic signed [62:0] disc_next;

    assign disc_next = 63'(qsq_p11_reg) - 63'(qsq_p02_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) disc_vld_reg <= 1'b0;
        else if (en) disc_vld_reg <= qsq_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            disc_x_reg         <= disc_next[62] ? '0 : disc_next[61:0];
            disc_flags_reg.hit <= qsq_qz_reg | !disc_next[62];
            disc_flags_reg.zs  <= qsq_qz_reg | disc_next[62] | (qsq_q0_reg <= 0);
            disc_q0_reg        <= qsq_q0_reg;
            disc_q1_reg        <= qsq_q1_reg;
            disc_dx_reg        <= qsq_dx_reg;
            disc_dy_reg        <= qsq_dy_reg;
        end
    end

    logic        sq1_vld;
    logic [30:0] sq1_root;
    logic [127:0] sq1_side;

    rsls_isqrt #(.IW(62), .SW(128)) u_sqrt_disc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (disc_vld_reg),
        .in_x     (disc_x_reg),
        .in_side  ({disc_q0_reg, disc_q1_reg, disc_dx_reg, disc_dy_reg, disc_flags_reg}),
        .out_vld  (sq1_vld),
        .out_root (sq1_root),
        .out_side (sq1_side)
    );

    // ---------------- nearer root ----------------
    logic                   num_vld_reg;
    logic [32+FRAC_BITS-1:0] num_n_reg;
    logic [29:0]            num_den_reg;
    logic                   num_neg_reg;
    logic signed [31:0]     num_dx_reg, num_dy_reg;
    rsls_pkg::flags_t       num_flags_reg;
    logic signed [32:0]     num_next;
    logic [32:0]            num_mag;
    logic signed [30:0]     sq1_q0, sq1_q1;

    assign sq1_q0   = sq1_side[127:97];
    assign sq1_q1   = sq1_side[96:66];
    assign num_next = -33'(sq1_q1) - $signed({2'b0, sq1_root});
    assign num_mag  = num_next[32] ? 33'(-num_next) : 33'(num_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) num_vld_reg <= 1'b0;
        else if (en) num_vld_reg <= sq1_vld;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_n_reg     <= {num_mag[31:0], {FRAC_BITS{1'b0}}};
            num_den_reg   <= sq1_q0[29:0];
            num_neg_reg   <= num_next[32];
            num_dx_reg    <= sq1_side[65:34];
            num_dy_reg    <= sq1_side[33:2];
            num_flags_reg <= rsls_pkg::flags_t'(sq1_side[1:0]);
        end
    end

    logic        dv1_vld;
    logic [31:0] dv1_quo;
    logic        dv1_ov;
    logic [66:0] dv1_side;

    rsls_div #(.NW(32 + FRAC_BITS), .DW(30), .QW(32), .SW(67)) u_div_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (num_vld_reg),
        .in_num   (num_n_reg),
        .in_den   (num_den_reg),
        .in_side  ({num_dx_reg, num_dy_reg, num_flags_reg, num_neg_reg}),
        .out_vld  (dv1_vld),
        .out_quo  (dv1_quo),
        .out_ov   (dv1_ov),
        .out_side (dv1_side)
    );

    logic               tpar_vld_reg;
    logic signed [31:0] tpar_t_reg, tpar_t_next;
    logic signed [31:0] tpar_dx_reg, tpar_dy_reg;
    rsls_pkg::flags_t   tpar_flags_reg;

    always_comb begin
        if (!dv1_side[0]) begin
            tpar_t_next = (dv1_ov || dv1_quo[31]) ? 32'sh7FFF_FFFF : $signed(dv1_quo);
        end else if (dv1_ov || (dv1_quo[31] && (|dv1_quo[30:0]))) begin
            tpar_t_next = 32'sh8000_0000;
        end else begin
            tpar_t_next = -$signed(dv1_quo);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) tpar_vld_reg <= 1'b0;
        else if (en) tpar_vld_reg <= dv1_vld;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tpar_t_reg     <= tpar_t_next;
            tpar_dx_reg    <= dv1_side[66:35];
            tpar_dy_reg    <= dv1_side[34:3];
            tpar_flags_reg <= rsls_pkg::flags_t'(dv1_side[2:1]);
        end
    end

    // ---------------- surface normal ----------------
    logic               tmul_vld_reg;
    logic signed [31:0] tvec [3];
    rsls_pkg::s64_t     tmul_p_reg [3];
    rsls_pkg::flags_t   tmul_flags_reg;

    always_comb begin
        tvec[0] = tpar_dx_reg;
        tvec[1] = tpar_dy_reg;
        tvec[2] = vdir_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) tmul_vld_reg <= 1'b0;
        else if (en) tmul_vld_reg <= tpar_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                tmul_p_reg[i] <= 64'(tpar_t_reg) * 64'(tvec[i]);
            end
            tmul_flags_reg <= tpar_flags_reg;
        end
    end

    logic             nrm_vld_reg;
    rsls_pkg::s64_t   nrm_n_reg [3];
    rsls_pkg::flags_t nrm_flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) nrm_vld_reg <= 1'b0;
        else if (en) nrm_vld_reg <= tmul_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                nrm_n_reg[i] <= 64'(off_reg[i]) + (tmul_p_reg[i] >>> FRAC_BITS);
            end
            nrm_flags_reg <= tmul_flags_reg;
        end
    end

    logic               n2_vld;
    logic signed [29:0] n2_v0, n2_v1, n2_v2;
    logic [1:0]         n2_side;

    rsls_norm3 #(.HB(29), .SW(2)) u_norm_normal (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (nrm_vld_reg),
        .in_v0    (nrm_n_reg[0]),
        .in_v1    (nrm_n_reg[1]),
        .in_v2    (nrm_n_reg[2]),
        .in_side  (nrm_flags_reg),
        .out_vld  (n2_vld),
        .out_v0   (n2_v0),
        .out_v1   (n2_v1),
        .out_v2   (n2_v2),
        .out_side (n2_side)
    );

    // ---------------- Lambert term ----------------
    logic               lam_vld_reg;
    logic signed [32:0] lam_dot_reg;
    logic [58:0]        lam_sq_reg [3];
    rsls_pkg::flags_t   lam_flags_reg;
    logic signed [59:0] lam_pr [3];

    always_comb begin
        lam_pr[0] = 60'(n2_v0) * 60'(n2_v0);
        lam_pr[1] = 60'(n2_v1) * 60'(n2_v1);
        lam_pr[2] = 60'(n2_v2) * 60'(n2_v2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) lam_vld_reg <= 1'b0;
        else if (en) lam_vld_reg <= n2_vld;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lam_dot_reg   <= (33'(n2_v0) <<< 1) - 33'(n2_v1) + 33'(n2_v2);
            for (int i = 0; i < 3; i++) lam_sq_reg[i] <= lam_pr[i][58:0];
            lam_flags_reg <= rsls_pkg::flags_t'(n2_side);
        end
    end

    logic             len_vld_reg;
    logic [59:0]      len_sum_reg;
    logic [30:0]      len_dot_reg;
    rsls_pkg::flags_t len_flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) len_vld_reg <= 1'b0;
        else if (en) len_vld_reg <= lam_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len_sum_reg       <= 60'(lam_sq_reg[0]) + 60'(lam_sq_reg[1]) + 60'(lam_sq_reg[2]);
            len_dot_reg       <= lam_dot_reg[30:0];
            len_flags_reg.hit <= lam_flags_reg.hit;
            len_flags_reg.zs  <= lam_flags_reg.zs | lam_dot_reg[32] | (lam_dot_reg == 0);
        end
    end

    logic             len6_vld_reg;
    logic [63:0]      len6_x_reg;
    logic [30:0]      len6_dot_reg;
    rsls_pkg::flags_t len6_flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) len6_vld_reg <= 1'b0;
        else if (en) len6_vld_reg <= len_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len6_x_reg     <= (64'(len_sum_reg) << 2) + (64'(len_sum_reg) << 1);
            len6_dot_reg   <= len_dot_reg;
            len6_flags_reg <= len_flags_reg;
        end
    end

    logic        sq2_vld;
    logic [31:0] sq2_root;
    logic [32:0] sq2_side;

    rsls_isqrt #(.IW(64), .SW(33)) u_sqrt_len (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (len6_vld_reg),
        .in_x     (len6_x_reg),
        .in_side  ({len6_dot_reg, len6_flags_reg}),
        .out_vld  (sq2_vld),
        .out_root (sq2_root),
        .out_side (sq2_side)
    );

    logic        dv2_vld;
    logic [15:0] dv2_quo;
    logic        dv2_ov;
    logic [1:0]  dv2_side;

    rsls_div #(.NW(47), .DW(32), .QW(16), .SW(2)) u_div_shade (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (sq2_vld),
        .in_num   ({sq2_side[32:2], 16'b0}),
        .in_den   (sq2_root),
        .in_side  (sq2_side[1:0]),
        .out_vld  (dv2_vld),
        .out_quo  (dv2_quo),
        .out_ov   (dv2_ov),
        .out_side (dv2_side)
    );

    // ---------------- output register and skid ----------------
    rsls_pkg::flags_t fin_flags;
    logic [15:0]      fin_shade;

    assign fin_flags = rsls_pkg::flags_t'(dv2_side);
    assign fin_shade = fin_flags.zs ? 16'd0 : (dv2_ov ? 16'hFFFF : dv2_quo);

    logic        out_vld_reg, out_hit_reg;
    logic [15:0] out_shade_reg;
    logic        skid_hit_reg;
    logic [15:0] skid_shade_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (out_vld_reg && !m_tready) begin
            if (en && dv2_vld) skid_vld_reg <= 1'b1;
        end else if (skid_vld_reg) begin
            out_vld_reg  <= 1'b1;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= dv2_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_vld_reg && !m_tready) begin
            if (en) begin
                skid_hit_reg   <= fin_flags.hit;
                skid_shade_reg <= fin_shade;
            end
        end else if (skid_vld_reg) begin
            out_hit_reg   <= skid_hit_reg;
            out_shade_reg <= skid_shade_reg;
        end else begin
            out_hit_reg   <= fin_flags.hit;
            out_shade_reg <= fin_shade;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_shade_reg;
    assign m_tuser  = out_hit_reg;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds a result while the output register is empty");

    a_miss_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !out_hit_reg) |-> (out_shade_reg == 16'd0))
        else $error("missed ray carries a nonzero shade");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_vld_reg && m_tready) |=> !skid_vld_reg)
        else $error("skid did not drain after the receiver took a result");

endmodule

`default_nettype wire
